// ----- src/segment_meter_resistance_alarm_top_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the resistance meter alarm block
// Clocked implication checks with an active-low reset guard.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_METER_RESISTANCE_ALARM_TOP_MACROS_SVH
`define SEGMENT_METER_RESISTANCE_ALARM_TOP_MACROS_SVH

// Same-cycle implication
`define SMRA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("smra check failed");

// Next-cycle implication
`define SMRA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("smra check failed");

`endif

// ----- src/smra_pkg.sv -----
// ----------------------------------------------------------------------------
// smra_pkg
// Shared widths, reset values, key codes, glyph table and types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package smra_pkg;

	localparam int OHMS_W  = 34;
	localparam int PCT_W   = 7;
	localparam int DIGIT_W = 4;
	localparam int NUM_DIGITS = 4;
	localparam int MM_W    = 41;
	localparam int PROD_W  = 42;

	localparam int QUEUE_DEPTH = 4;

	localparam logic [OHMS_W-1:0] OVERLOAD_OHMS = 34'd50000000;
	localparam logic [OHMS_W-1:0] RESET_OHMS    = 34'd1000000;
	localparam logic [PCT_W-1:0]  RESET_LED_PCT = 7'd75;
	localparam logic [PCT_W-1:0]  RESET_BUZ_PCT = 7'd85;
	localparam logic [PCT_W-1:0]  PCT_FULL      = 7'd100;
	localparam logic [PCT_W-1:0]  PCT_MIN       = 7'd5;
	localparam logic [PCT_W-1:0]  PCT_STEP      = 7'd5;

	// Key codes
	localparam logic [2:0] KEY_NONE      = 3'd0;
	localparam logic [2:0] KEY_LED_UP    = 3'd1;
	localparam logic [2:0] KEY_LED_DOWN  = 3'd2;
	localparam logic [2:0] KEY_BUZ_UP    = 3'd3;
	localparam logic [2:0] KEY_BUZ_DOWN  = 3'd4;
	localparam logic [2:0] KEY_TOGGLE    = 3'd5;
	localparam logic [2:0] KEY_LATCH_REF = 3'd6;

	localparam logic KIND_FRAME = 1'b0;

	// Segment patterns for 0..9 and the 'L' glyph
	localparam int GLYPH_COUNT = 11;
	localparam logic [DIGIT_W-1:0] DIGIT_L = 4'd10;
	localparam logic [6:0] GLYPH [GLYPH_COUNT] = '{
		7'h7E, 7'h30, 7'h6D, 7'h79, 7'h33, 7'h5B, 7'h5F, 7'h70, 7'h7F, 7'h7B, 7'h0E
	};

	// Per-item state snapshot handed from front to back
	typedef struct packed {
		logic [OHMS_W-1:0] measured;
		logic [OHMS_W-1:0] reference;
		logic [PCT_W-1:0]  led_pct;
		logic [PCT_W-1:0]  buz_pct;
		logic              alarm_on;
		logic              overload;
	} snap_t;

	// Return {hit, value} for a segment pattern
	function automatic logic [DIGIT_W:0] decode_glyph(input logic [6:0] pat);
		logic [DIGIT_W:0] r;
		r = '0;
		for (int g = 0; g < GLYPH_COUNT; g++) begin
			if (pat == GLYPH[g]) begin
				r = {1'b1, DIGIT_W'(g)};
			end
		end
		return r;
	endfunction

endpackage

// ----- src/smra_if.sv -----
// ----------------------------------------------------------------------------
// smra_item_if / smra_result_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface smra_item_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [31:0] segment_nibbles;
	logic        unit_kilo;
	logic        unit_mega;
	logic [2:0]  key_code;

	modport source (output valid, kind, segment_nibbles, unit_kilo, unit_mega, key_code,
		input ready);
	modport sink (input valid, kind, segment_nibbles, unit_kilo, unit_mega, key_code,
		output ready);
endinterface

interface smra_result_if;
	logic                             valid;
	logic                             ready;
	logic [smra_pkg::OHMS_W-1:0]      resistance_ohms;
	logic                             overload;
	logic                             led_alarm;
	logic                             buzzer_alarm;
	logic                             alarm_enabled;
	logic [smra_pkg::PCT_W-1:0]       led_threshold_pct;
	logic [smra_pkg::PCT_W-1:0]       buzzer_threshold_pct;
	logic [smra_pkg::OHMS_W-1:0]      reference_ohms;

	modport source (output valid, resistance_ohms, overload, led_alarm, buzzer_alarm,
		alarm_enabled, led_threshold_pct, buzzer_threshold_pct, reference_ohms,
		input ready);
	modport sink (input valid, resistance_ohms, overload, led_alarm, buzzer_alarm,
		alarm_enabled, led_threshold_pct, buzzer_threshold_pct, reference_ohms,
		output ready);
	modport monitor (input valid, ready, resistance_ohms, overload, led_alarm,
		buzzer_alarm, alarm_enabled, led_threshold_pct, buzzer_threshold_pct,
		reference_ohms);
endinterface

// ----- src/smra_front.sv -----
// ----------------------------------------------------------------------------
// smra_front
// Accepts items, decodes frames, applies keys and pushes a state snapshot.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module smra_front (
	input  logic              clk,
	input  logic              arst_n,
	smra_item_if.sink         item,
	output logic              push_valid,
	output smra_pkg::snap_t   push_data,
	input  logic              push_ready
);

	localparam int DW = smra_pkg::DIGIT_W;
	localparam int OW = smra_pkg::OHMS_W;
	localparam int PW = smra_pkg::PCT_W;

	logic [DW-1:0] digits_q [smra_pkg::NUM_DIGITS];
	logic [OW-1:0] measured_q;
	logic [OW-1:0] reference_q;
	logic [PW-1:0] led_pct_q;
	logic [PW-1:0] buz_pct_q;
	logic          alarm_on_q;

	logic [DW-1:0] digits_n [smra_pkg::NUM_DIGITS];
	logic [OW-1:0] measured_n;
	logic [OW-1:0] reference_n;
	logic [PW-1:0] led_pct_n;
	logic [PW-1:0] buz_pct_n;
	logic          alarm_on_n;

	logic          accept;
	logic          is_frame;
	logic [13:0]   value_full;
	logic [13:0]   part1;
	logic [13:0]   part2;
	logic [13:0]   part3;
	logic [13:0]   operand;
	logic [19:0]   scale;
	logic [OW-1:0] scaled;
	logic          dp0;
	logic          dp1;
	logic          dp2;

	assign accept     = item.valid && push_ready;
	assign item.ready = push_ready;
	assign is_frame   = (item.kind == smra_pkg::KIND_FRAME);
	assign dp0        = item.segment_nibbles[11];
	assign dp1        = item.segment_nibbles[19];
	assign dp2        = item.segment_nibbles[27];

	// Decode each digit; an unknown pattern keeps the old value
	always_comb begin
		logic [3:0]    a;
		logic [3:0]    b;
		logic [6:0]    pat;
		logic [DW:0]   dec;
		for (int j = 0; j < smra_pkg::NUM_DIGITS; j++) begin
			a   = item.segment_nibbles[8*j +: 4];
			b   = item.segment_nibbles[8*j+4 +: 4];
			pat = {a[0], b[0], b[2], b[3], a[2], a[1], b[1]};
			dec = smra_pkg::decode_glyph(pat);
			digits_n[j] = dec[DW] ? dec[DW-1:0] : digits_q[j];
		end
	end

	// Form the digit sums
	assign part1 = 14'(digits_n[0]);
	assign part2 = 14'(digits_n[0]) * 14'd10 + 14'(digits_n[1]);
	assign part3 = 14'(digits_n[0]) * 14'd100 + 14'(digits_n[1]) * 14'd10
		+ 14'(digits_n[2]);
	assign value_full = 14'(digits_n[0]) * 14'd1000 + 14'(digits_n[1]) * 14'd100
		+ 14'(digits_n[2]) * 14'd10 + 14'(digits_n[3]);

	// Select scaling by unit, then decimal point
	always_comb begin
		operand = value_full;
		if (item.unit_kilo) begin
			scale = dp0 ? 20'd1 : dp1 ? 20'd10 : dp2 ? 20'd100 : 20'd1000;
		end else if (item.unit_mega) begin
			scale = dp0 ? 20'd1000 : dp1 ? 20'd10000 : dp2 ? 20'd100000 : 20'd1000000;
		end else begin
			scale   = 20'd1;
			operand = dp0 ? part1 : dp1 ? part2 : dp2 ? part3 : value_full;
		end
	end

	assign scaled = OW'(OW'(operand) * OW'(scale));

	// Next state for this transaction
	always_comb begin
		measured_n  = measured_q;
		reference_n = reference_q;
		led_pct_n   = led_pct_q;
		buz_pct_n   = buz_pct_q;
		alarm_on_n  = alarm_on_q;
		if (is_frame) begin
			measured_n = (digits_n[2] == smra_pkg::DIGIT_L) ? smra_pkg::OVERLOAD_OHMS
				: scaled;
		end else begin
			case (item.key_code)
				smra_pkg::KEY_LED_UP: begin
					led_pct_n = (led_pct_q < smra_pkg::PCT_FULL)
						? led_pct_q + smra_pkg::PCT_STEP : smra_pkg::PCT_FULL;
				end
				smra_pkg::KEY_LED_DOWN: begin
					led_pct_n = (led_pct_q > smra_pkg::PCT_MIN)
						? led_pct_q - smra_pkg::PCT_STEP : smra_pkg::PCT_MIN;
				end
				smra_pkg::KEY_BUZ_UP: begin
					buz_pct_n = (buz_pct_q < smra_pkg::PCT_FULL)
						? buz_pct_q + smra_pkg::PCT_STEP : smra_pkg::PCT_FULL;
				end
				smra_pkg::KEY_BUZ_DOWN: begin
					buz_pct_n = (buz_pct_q > smra_pkg::PCT_MIN)
						? buz_pct_q - smra_pkg::PCT_STEP : smra_pkg::PCT_MIN;
				end
				smra_pkg::KEY_TOGGLE: begin
					alarm_on_n = ~alarm_on_q;
				end
				smra_pkg::KEY_LATCH_REF: begin
					reference_n = measured_q;
				end
				default: begin
				end
			endcase
		end
	end

	// Commit state on each accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < smra_pkg::NUM_DIGITS; j++) begin
				digits_q[j] <= '0;
			end
			measured_q  <= smra_pkg::RESET_OHMS;
			reference_q <= smra_pkg::RESET_OHMS;
			led_pct_q   <= smra_pkg::RESET_LED_PCT;
			buz_pct_q   <= smra_pkg::RESET_BUZ_PCT;
			alarm_on_q  <= 1'b1;
		end else if (accept) begin
			if (is_frame) begin
				for (int j = 0; j < smra_pkg::NUM_DIGITS; j++) begin
					digits_q[j] <= digits_n[j];
				end
			end
			measured_q  <= measured_n;
			reference_q <= reference_n;
			led_pct_q   <= led_pct_n;
			buz_pct_q   <= buz_pct_n;
			alarm_on_q  <= alarm_on_n;
		end
	end

	// Hand the post-update state to the queue
	assign push_valid          = accept;
	assign push_data.measured  = measured_n;
	assign push_data.reference = reference_n;
	assign push_data.led_pct   = led_pct_n;
	assign push_data.buz_pct   = buz_pct_n;
	assign push_data.alarm_on  = alarm_on_n;
	assign push_data.overload  = (measured_n == smra_pkg::OVERLOAD_OHMS);

endmodule

// ----- src/smra_queue.sv -----
// ----------------------------------------------------------------------------
// smra_queue
// Small register FIFO of state snapshots between front and back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module smra_queue #(
	parameter int DEPTH = smra_pkg::QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push_valid,
	input  smra_pkg::snap_t   push_data,
	output logic              push_ready,
	output logic              pop_valid,
	output smra_pkg::snap_t   pop_data,
	input  logic              pop_ready
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST  = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL  = CNT_W'(DEPTH);

	smra_pkg::snap_t  mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != FULL);
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// Store entries
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- src/smra_back.sv -----
// ----------------------------------------------------------------------------
// smra_back
// Computes the band limits, compares and drives the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module smra_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              pop_valid,
	input  smra_pkg::snap_t   pop_data,
	output logic              pop_ready,
	smra_result_if.source     result
);

	localparam int OW = smra_pkg::OHMS_W;
	localparam int PW = smra_pkg::PCT_W;
	localparam int MW = smra_pkg::MM_W;
	localparam int QW = smra_pkg::PROD_W;

	// Stage 1: products
	logic          valid_s1;
	logic [MW-1:0] mm_s1;
	logic [QW-1:0] led_lo_s1;
	logic [QW-1:0] led_hi_s1;
	logic [QW-1:0] buz_lo_s1;
	logic [QW-1:0] buz_hi_s1;
	logic          check_s1;
	smra_pkg::snap_t snap_s1;

	// Output register
	logic          out_valid_q;
	logic [OW-1:0] ohms_q;
	logic          overload_q;
	logic          led_alarm_q;
	logic          buz_alarm_q;
	logic          alarm_on_q;
	logic [PW-1:0] led_pct_q;
	logic [PW-1:0] buz_pct_q;
	logic [OW-1:0] reference_q;

	logic          out_free;
	logic          s1_ready;
	logic [QW-1:0] mm_ext;

	assign out_free  = !out_valid_q || result.ready;
	assign s1_ready  = !valid_s1 || out_free;
	assign pop_ready = s1_ready;
	assign mm_ext    = QW'(mm_s1);

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_ready) begin
				valid_s1 <= pop_valid;
			end
			if (out_free) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	// Multiply measurement and reference by the band factors
	always_ff @(posedge clk) begin
		if (s1_ready && pop_valid) begin
			mm_s1     <= MW'(MW'(pop_data.measured) * MW'(smra_pkg::PCT_FULL));
			led_lo_s1 <= QW'(QW'(pop_data.reference)
				* QW'(smra_pkg::PCT_FULL - pop_data.led_pct));
			led_hi_s1 <= QW'(QW'(pop_data.reference)
				* QW'({1'b0, smra_pkg::PCT_FULL} + {1'b0, pop_data.led_pct}));
			buz_lo_s1 <= QW'(QW'(pop_data.reference)
				* QW'(smra_pkg::PCT_FULL - pop_data.buz_pct));
			buz_hi_s1 <= QW'(QW'(pop_data.reference)
				* QW'({1'b0, smra_pkg::PCT_FULL} + {1'b0, pop_data.buz_pct}));
			check_s1  <= pop_data.alarm_on && !pop_data.overload;
			snap_s1   <= pop_data;
		end
	end

	// Compare against the bands and load the result
	always_ff @(posedge clk) begin
		if (out_free && valid_s1) begin
			led_alarm_q <= check_s1 && ((mm_ext < led_lo_s1) || (mm_ext > led_hi_s1));
			buz_alarm_q <= check_s1 && ((mm_ext < buz_lo_s1) || (mm_ext > buz_hi_s1));
			ohms_q      <= snap_s1.measured;
			overload_q  <= snap_s1.overload;
			alarm_on_q  <= snap_s1.alarm_on;
			led_pct_q   <= snap_s1.led_pct;
			buz_pct_q   <= snap_s1.buz_pct;
			reference_q <= snap_s1.reference;
		end
	end

	assign result.valid                = out_valid_q;
	assign result.resistance_ohms      = ohms_q;
	assign result.overload             = overload_q;
	assign result.led_alarm            = led_alarm_q;
	assign result.buzzer_alarm         = buz_alarm_q;
	assign result.alarm_enabled        = alarm_on_q;
	assign result.led_threshold_pct    = led_pct_q;
	assign result.buzzer_threshold_pct = buz_pct_q;
	assign result.reference_ohms       = reference_q;

endmodule

// ----- src/segment_meter_resistance_alarm_top.sv -----
// Path: each accepted item passes through a queue entry, the product stage and the output register.
// Throughput: one item per cycle while the queue has room; the front updates its state on every accepted item.
// The queue of QUEUE_DEPTH entries and the two back stages absorb output stalls.
// Reset: arst_n clears all digits, sets 1 Mohm measurement and reference, bands 75/85 %,
// alarm enabled, and empties the queue and pipeline.
// ----------------------------------------------------------------------------
// segment_meter_resistance_alarm_top
// Seven-segment resistance reading with percentage band alarms.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module segment_meter_resistance_alarm_top #(
	parameter int QUEUE_DEPTH = smra_pkg::QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	smra_item_if.sink     item,
	smra_result_if.source result
);

	logic            push_valid;
	logic            push_ready;
	smra_pkg::snap_t push_data;
	logic            pop_valid;
	logic            pop_ready;
	smra_pkg::snap_t pop_data;

	// Accept and apply items
	smra_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.push_valid (push_valid),
		.push_data  (push_data),
		.push_ready (push_ready)
	);

	// Decouple front and back
	smra_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_data  (push_data),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_data   (pop_data),
		.pop_ready  (pop_ready)
	);

	// Evaluate alarms and drive results
	smra_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_data  (pop_data),
		.pop_ready (pop_ready),
		.result    (result)
	);

endmodule

// ----- src/smra_checker.sv -----
// ----------------------------------------------------------------------------
// smra_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "segment_meter_resistance_alarm_top_macros.svh"

module smra_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         valid,
	input logic                         ready,
	input logic [smra_pkg::OHMS_W-1:0]  ohms,
	input logic                         overload,
	input logic                         led_alarm,
	input logic                         buzzer_alarm,
	input logic                         enabled,
	input logic [smra_pkg::PCT_W-1:0]   led_pct,
	input logic [smra_pkg::PCT_W-1:0]   buz_pct
);

	logic pct_ok;
	logic alarms_quiet;

	// Both thresholds inside their limits
	assign pct_ok = (led_pct >= smra_pkg::PCT_MIN) && (led_pct <= smra_pkg::PCT_FULL)
		&& (buz_pct >= smra_pkg::PCT_MIN) && (buz_pct <= smra_pkg::PCT_FULL);
	assign alarms_quiet = !led_alarm && !buzzer_alarm;

	// Stalled transaction holds
	`SMRA_ASSERT_NEXT(a_stall_hold, clk, arst_n, valid && !ready, valid && $stable(ohms) && $stable(led_alarm))

	// Overload suppresses both alarms
	`SMRA_ASSERT_NOW(a_ovl_quiet, clk, arst_n, valid && overload, alarms_quiet)

	// Overload flag matches the overload reading
	`SMRA_ASSERT_NOW(a_ovl_value, clk, arst_n, valid && overload, ohms == smra_pkg::OVERLOAD_OHMS)

	// Disabled alarm raises nothing
	`SMRA_ASSERT_NOW(a_disabled, clk, arst_n, valid && !enabled, alarms_quiet)

	// Thresholds stay within their limits
	`SMRA_ASSERT_NOW(a_pct_range, clk, arst_n, valid, pct_ok)

endmodule

bind segment_meter_resistance_alarm_top smra_checker u_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.valid        (result.valid),
	.ready        (result.ready),
	.ohms         (result.resistance_ohms),
	.overload     (result.overload),
	.led_alarm    (result.led_alarm),
	.buzzer_alarm (result.buzzer_alarm),
	.enabled      (result.alarm_enabled),
	.led_pct      (result.led_threshold_pct),
	.buz_pct      (result.buzzer_threshold_pct)
);
